>>> hdl/sfd_pkg.sv
`timescale 1ns / 1ps
package sfd_pkg;

   // field widths fixed by the register map
   localparam int DLY_BITS  = 12;
   localparam int FB_BITS   = 15;
   localparam int GAIN_BITS = 16;
   localparam int CSR_BITS  = 16;

   // Q1.15 unity, one bit wider than the gain fields, and the feedback ceiling
   localparam logic [GAIN_BITS:0] GAIN_ONE     = 17'd32768;
   localparam logic [FB_BITS-1:0] FEEDBACK_MAX = 15'd32112;

   typedef enum logic [1:0] {
      CSR_DELAY    = 2'd0,
      CSR_FEEDBACK = 2'd1,
      CSR_MIX      = 2'd2,
      CSR_TONE     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      JMP_NEXT       = 2'd0,
      JMP_WAIT_CLEAR = 2'd1,
      JMP_WAIT_ITEM  = 2'd2,
      JMP_WAIT_OUT   = 2'd3
   } jump_type;

   typedef logic [2:0] step_type;

   localparam step_type ST_CLEAR    = 3'd0;
   localparam step_type ST_IDLE     = 3'd1;
   localparam step_type ST_MUL_GAIN = 3'd2;
   localparam step_type ST_BLEND    = 3'd3;
   localparam step_type ST_MUL_FB   = 3'd4;
   localparam step_type ST_WRITE    = 3'd5;

   typedef struct packed {
      logic     ram_clear;
      logic     take_item;
      logic     mul_gain;
      logic     sum_blend;
      logic     mul_fb;
      logic     write_back;
      jump_type jump;
      step_type next;
   } uword_type;

   // microprogram: one control word per step
   function automatic uword_type ucode(input step_type step);
      uword_type uw;
      uw = '{ram_clear: 1'b0, take_item: 1'b0, mul_gain: 1'b0, sum_blend: 1'b0,
             mul_fb: 1'b0, write_back: 1'b0, jump: JMP_NEXT, next: ST_IDLE};
      case (step)
         ST_CLEAR: begin
            uw.ram_clear = 1'b1;
            uw.jump      = JMP_WAIT_CLEAR;
            uw.next      = ST_IDLE;
         end
         ST_IDLE: begin
            uw.take_item = 1'b1;
            uw.jump      = JMP_WAIT_ITEM;
            uw.next      = ST_MUL_GAIN;
         end
         ST_MUL_GAIN: begin
            uw.mul_gain = 1'b1;
            uw.next     = ST_BLEND;
         end
         ST_BLEND: begin
            uw.sum_blend = 1'b1;
            uw.next      = ST_MUL_FB;
         end
         ST_MUL_FB: begin
            uw.mul_fb = 1'b1;
            uw.next   = ST_WRITE;
         end
         ST_WRITE: begin
            uw.write_back = 1'b1;
            uw.jump       = JMP_WAIT_OUT;
            uw.next       = ST_IDLE;
         end
         default: begin
            uw.next = ST_IDLE;
         end
      endcase
      return uw;
   endfunction

endpackage

>>> hdl/sfd_ram.sv
`timescale 1ns / 1ps
module sfd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/stereo_feedback_delay_unit.sv
`timescale 1ns / 1ps
// After reset the sample buffers are swept to zero, one address a cycle, over all
// DEPTH addresses (4096 by default); req_stall stays high during the sweep, register
// writes are taken. An item is taken in the idle step, and its result shows on rsp_valid
// at the end of its write-back step; the next item waits until then. Each item runs the
// five-step microprogram loop (read, gain products, blend, feedback product, write-back)
// around one registered-read RAM per channel. A stalled result holds the write-back step.
module stereo_feedback_delay_unit
   import sfd_pkg::*;
#(
   parameter int DEPTH       = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_left_in,
   input  logic signed [SAMPLE_BITS-1:0] req_right_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_out,
   input  logic                          csr_wr_en,
   input  logic [1:0]                    csr_index,
   input  logic [CSR_BITS-1:0]           csr_data
);

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SB   = SAMPLE_BITS;
   localparam int PW   = SB + 18;
   localparam int BW   = SB + 16;
   localparam int HW   = BW - 16;
   localparam int HPW  = HW + 16;
   localparam int LPW  = 16 + FB_BITS;
   localparam int ACCW = SB + 32;
   localparam int RW   = ACCW - 30;
   localparam int CMPW = ((AW > DLY_BITS) ? AW : DLY_BITS) + 1;

   localparam logic signed [PW-1:0]   HALF_MIX = PW'(64'sd1 <<< 14);
   localparam logic signed [ACCW-1:0] HALF_FB  = ACCW'(64'sd1 <<< 29);
   localparam logic signed [RW-1:0]   SMAX     = RW'((64'sd1 <<< (SB - 1)) - 64'sd1);
   localparam logic signed [RW-1:0]   SMIN     = RW'(-(64'sd1 <<< (SB - 1)));

   // control
   step_type      step_ff, step_in;
   uword_type     uw;
   logic          advance;
   logic          clr_done;
   logic          out_free;
   logic          take;
   logic [AW-1:0] clr_ptr_ff, clr_ptr_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [DLY_BITS-1:0]  delay_ff, delay_in;
   logic [FB_BITS-1:0]   fb_ff, fb_in;
   logic [GAIN_BITS-1:0] mix_ff, mix_in;
   logic [GAIN_BITS-1:0] tone_ff, tone_in;

   logic [FB_BITS-1:0]   fb_c;
   logic [GAIN_BITS:0]   mix_c, nmix_c, tone_c, ntone_c;
   logic [CMPW-1:0]      dly_ext, d_c, wp_ext, rd_full;
   logic [AW-1:0]        rd_addr;

   // per-channel datapath, lane 0 left, lane 1 right
   logic signed [SB-1:0]   smp_ff [2], smp_in [2];
   logic signed [PW-1:0]   p_dt_ff [2], p_dt_in [2];
   logic signed [PW-1:0]   p_nt_ff [2], p_nt_in [2];
   logic signed [PW-1:0]   p_dm_ff [2], p_dm_in [2];
   logic signed [PW-1:0]   p_nm_ff [2], p_nm_in [2];
   logic signed [BW-1:0]   blend_ff [2], blend_in [2];
   logic signed [SB-1:0]   mixo_ff [2], mixo_in [2];
   logic signed [HPW-1:0]  hi_p_ff [2], hi_p_in [2];
   logic [LPW-1:0]         lo_p_ff [2], lo_p_in [2];
   logic signed [SB-1:0]   rsp_out_ff [2], rsp_out_in [2];
   logic signed [SB-1:0]   stored [2];
   logic [SB-1:0]          rd_data [2];

   logic signed [SB-1:0]   req_smp [2];
   logic signed [PW-1:0]   msum [2];
   logic signed [ACCW-1:0] acc [2];
   logic signed [RW-1:0]   rnd [2];

   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;

   assign req_smp[0] = req_left_in;
   assign req_smp[1] = req_right_in;

   // sequencer
   always_comb begin
      uw       = ucode(step_ff);
      clr_done = (clr_ptr_ff == AW'(DEPTH - 1));
      out_free = !rsp_valid_ff || !rsp_stall;
      case (uw.jump)
         JMP_NEXT:       advance = 1'b1;
         JMP_WAIT_CLEAR: advance = clr_done;
         JMP_WAIT_ITEM:  advance = req_valid;
         JMP_WAIT_OUT:   advance = out_free;
         default:        advance = 1'b1;
      endcase
      step_in = advance ? uw.next : step_ff;
   end

   assign req_stall = !uw.take_item;
   assign take      = uw.take_item && req_valid;

   // clamp the gains and the delay at use
   always_comb begin
      fb_c    = (fb_ff > FEEDBACK_MAX) ? FEEDBACK_MAX : fb_ff;
      mix_c   = ({1'b0, mix_ff} > GAIN_ONE) ? GAIN_ONE : {1'b0, mix_ff};
      tone_c  = ({1'b0, tone_ff} > GAIN_ONE) ? GAIN_ONE : {1'b0, tone_ff};
      nmix_c  = GAIN_ONE - mix_c;
      ntone_c = GAIN_ONE - tone_c;
      dly_ext = CMPW'(delay_ff);
      if (dly_ext == '0) begin
         d_c = CMPW'(1);
      end else if (dly_ext > CMPW'(DEPTH - 1)) begin
         d_c = CMPW'(DEPTH - 1);
      end else begin
         d_c = dly_ext;
      end
      wp_ext  = CMPW'(wp_ff);
      rd_full = (wp_ext >= d_c) ? (wp_ext - d_c) : (wp_ext + CMPW'(DEPTH) - d_c);
      rd_addr = rd_full[AW-1:0];
   end

   // datapath
   always_comb begin
      for (int c = 0; c < 2; c++) begin
         smp_in[c]     = take ? req_smp[c] : smp_ff[c];
         p_dt_in[c]    = p_dt_ff[c];
         p_nt_in[c]    = p_nt_ff[c];
         p_dm_in[c]    = p_dm_ff[c];
         p_nm_in[c]    = p_nm_ff[c];
         blend_in[c]   = blend_ff[c];
         mixo_in[c]    = mixo_ff[c];
         hi_p_in[c]    = hi_p_ff[c];
         lo_p_in[c]    = lo_p_ff[c];
         rsp_out_in[c] = rsp_out_ff[c];

         if (uw.mul_gain) begin
            p_dt_in[c] = PW'($signed(rd_data[c])) * PW'($signed({1'b0, tone_c}));
            p_nt_in[c] = PW'(smp_ff[c]) * PW'($signed({1'b0, ntone_c}));
            p_dm_in[c] = PW'($signed(rd_data[c])) * PW'($signed({1'b0, mix_c}));
            p_nm_in[c] = PW'(smp_ff[c]) * PW'($signed({1'b0, nmix_c}));
         end

         msum[c] = p_dm_ff[c] + p_nm_ff[c] + HALF_MIX;
         if (uw.sum_blend) begin
            blend_in[c] = BW'(p_dt_ff[c] + p_nt_ff[c]);
            mixo_in[c]  = SB'(msum[c] >>> 15);
         end

         // split the blend so each product stays narrow
         if (uw.mul_fb) begin
            hi_p_in[c] = HPW'($signed(blend_ff[c][BW-1:16])) *
                         HPW'($signed({1'b0, fb_c}));
            lo_p_in[c] = LPW'(blend_ff[c][15:0]) * LPW'(fb_c);
         end

         acc[c] = (ACCW'(smp_ff[c]) <<< 30) + (ACCW'(hi_p_ff[c]) <<< 16) +
                  $signed(ACCW'(lo_p_ff[c])) + HALF_FB;
         rnd[c] = RW'(acc[c] >>> 30);
         if (rnd[c] > SMAX) begin
            stored[c] = SB'(SMAX);
         end else if (rnd[c] < SMIN) begin
            stored[c] = SB'(SMIN);
         end else begin
            stored[c] = SB'(rnd[c]);
         end

         if (uw.write_back && out_free) begin
            rsp_out_in[c] = mixo_ff[c];
         end
      end
   end

   // buffers: zero sweep after reset, then write-back at the write pointer
   assign ram_we    = uw.ram_clear || (uw.write_back && out_free);
   assign ram_waddr = uw.ram_clear ? clr_ptr_ff : wp_ff;

   for (genvar c = 0; c < 2; c++) begin : g_lane
      sfd_ram #(
         .WIDTH (SB),
         .DEPTH (DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ram_we),
         .wr_addr (ram_waddr),
         .wr_data (uw.ram_clear ? '0 : stored[c]),
         .rd_addr (rd_addr),
         .rd_data (rd_data[c])
      );
   end

   always_comb begin
      clr_ptr_in = clr_ptr_ff;
      if (uw.ram_clear && !clr_done) begin
         clr_ptr_in = clr_ptr_ff + AW'(1);
      end
      wp_in = wp_ff;
      if (uw.write_back && out_free) begin
         wp_in = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + AW'(1);
      end
      if (uw.write_back && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // register writes, extra bits dropped
   always_comb begin
      delay_in = delay_ff;
      fb_in    = fb_ff;
      mix_in   = mix_ff;
      tone_in  = tone_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_DELAY:    delay_in = csr_data[DLY_BITS-1:0];
            CSR_FEEDBACK: fb_in    = csr_data[FB_BITS-1:0];
            CSR_MIX:      mix_in   = csr_data[GAIN_BITS-1:0];
            CSR_TONE:     tone_in  = csr_data[GAIN_BITS-1:0];
            default:      delay_in = delay_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_CLEAR;
         clr_ptr_ff   <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         delay_ff     <= DLY_BITS'(1);
         fb_ff        <= '0;
         mix_ff       <= '0;
         tone_ff      <= '0;
      end else begin
         step_ff      <= step_in;
         clr_ptr_ff   <= clr_ptr_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
         delay_ff     <= delay_in;
         fb_ff        <= fb_in;
         mix_ff       <= mix_in;
         tone_ff      <= tone_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 2; c++) begin
         smp_ff[c]     <= smp_in[c];
         p_dt_ff[c]    <= p_dt_in[c];
         p_nt_ff[c]    <= p_nt_in[c];
         p_dm_ff[c]    <= p_dm_in[c];
         p_nm_ff[c]    <= p_nm_in[c];
         blend_ff[c]   <= blend_in[c];
         mixo_ff[c]    <= mixo_in[c];
         hi_p_ff[c]    <= hi_p_in[c];
         lo_p_ff[c]    <= lo_p_in[c];
         rsp_out_ff[c] <= rsp_out_in[c];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_out_ff[0];
   assign rsp_right_out = rsp_out_ff[1];

endmodule

>>> tb/sv/stereo_feedback_delay_checker.sv
`timescale 1ns / 1ps
module stereo_feedback_delay_checker
   import sfd_pkg::*;
#(
   parameter int DEPTH       = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_left_in,
   input  logic signed [SAMPLE_BITS-1:0] req_right_in,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   input  logic signed [SAMPLE_BITS-1:0] rsp_right_out,
   input  logic                          csr_wr_en,
   input  logic [1:0]                    csr_index,
   input  logic [CSR_BITS-1:0]           csr_data,
   output int                            mismatch_count,
   output int                            pending_count
);

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
   } stereo_pair_type;

   localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_LO = -SAMPLE_HI - 1;

   stereo_pair_type mixed_queue [$];

   logic [DLY_BITS-1:0]           delay_reg;
   logic [FB_BITS-1:0]            feedback_reg;
   logic [GAIN_BITS-1:0]          mix_reg;
   logic [GAIN_BITS-1:0]          tone_reg;
   logic signed [SAMPLE_BITS-1:0] left_line [DEPTH];
   logic signed [SAMPLE_BITS-1:0] right_line [DEPTH];
   int                            head;

   // round to nearest, ties toward plus infinity
   function automatic longint round_q(input longint x, input int s);
      return (x + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clip(input longint v);
      if (v > SAMPLE_HI) return SAMPLE_HI;
      if (v < SAMPLE_LO) return SAMPLE_LO;
      return v;
   endfunction

   function automatic void echo_channel(input longint dry, input longint wet,
                                        input longint fb, input longint mix,
                                        input longint tone,
                                        output logic signed [SAMPLE_BITS-1:0] stored,
                                        output logic signed [SAMPLE_BITS-1:0] mixed);
      longint blend;
      longint acc;
      blend  = wet * tone + dry * (longint'(GAIN_ONE) - tone);
      acc    = dry * (longint'(1) <<< 30) + blend * fb;
      stored = SAMPLE_BITS'(clip(round_q(acc, 30)));
      mixed  = SAMPLE_BITS'(clip(round_q(dry * (longint'(GAIN_ONE) - mix) + wet * mix, 15)));
   endfunction

   always @(posedge clock) begin
      int              d;
      int              rd;
      longint          fb;
      longint          mix;
      longint          tone;
      stereo_pair_type got;
      stereo_pair_type want;
      logic signed [SAMPLE_BITS-1:0] left_stored;
      logic signed [SAMPLE_BITS-1:0] right_stored;

      if (reset) begin
         delay_reg      = DLY_BITS'(1);
         feedback_reg   = '0;
         mix_reg        = '0;
         tone_reg       = '0;
         mismatch_count = 0;
         for (int i = 0; i < DEPTH; i++) begin
            left_line[i]  = '0;
            right_line[i] = '0;
         end
         head = 0;
         mixed_queue.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DELAY:    delay_reg    = csr_data[DLY_BITS-1:0];
               CSR_FEEDBACK: feedback_reg = csr_data[FB_BITS-1:0];
               CSR_MIX:      mix_reg      = csr_data[GAIN_BITS-1:0];
               CSR_TONE:     tone_reg     = csr_data[GAIN_BITS-1:0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            d = int'(delay_reg);
            if (d < 1) d = 1;
            if (d > DEPTH - 1) d = DEPTH - 1;
            fb   = (feedback_reg > FEEDBACK_MAX) ? longint'(FEEDBACK_MAX)
                                                 : longint'(feedback_reg);
            mix  = ({1'b0, mix_reg} > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(mix_reg);
            tone = ({1'b0, tone_reg} > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(tone_reg);
            rd   = (head + DEPTH - d) % DEPTH;
            echo_channel(longint'(req_left_in), longint'(left_line[rd]), fb, mix, tone,
                         left_stored, want.left);
            echo_channel(longint'(req_right_in), longint'(right_line[rd]), fb, mix, tone,
                         right_stored, want.right);
            left_line[head]  = left_stored;
            right_line[head] = right_stored;
            head = (head + 1) % DEPTH;
            mixed_queue.push_back(want);
         end

         if (rsp_valid && !rsp_stall) begin
            got.left  = rsp_left_out;
            got.right = rsp_right_out;
            if (mixed_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected item left %0d right %0d", $realtime,
                           got.left, got.right);
            end else begin
               want = mixed_queue.pop_front();
               if (got.left !== want.left || got.right !== want.right) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: mismatch left exp %0d got %0d, right exp %0d got %0d",
                              $realtime, want.left, got.left, want.right, got.right);
               end
            end
         end
      end
      pending_count = mixed_queue.size();
   end

endmodule

>>> tb/sv/stereo_feedback_delay_unit_test.sv
`timescale 1ns / 1ps
module stereo_feedback_delay_unit_test
   import sfd_pkg::*;
;

   localparam int DEPTH       = 4096;
   localparam int SAMPLE_BITS = 16;
   localparam int PHASE_ITEMS = 153;

   logic                          clock;
   logic                          reset        = 1'b1;
   logic                          req_valid    = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_left_in  = '0;
   logic signed [SAMPLE_BITS-1:0] req_right_in = '0;
   logic                          rsp_valid;
   logic                          rsp_stall    = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_left_out;
   logic signed [SAMPLE_BITS-1:0] rsp_right_out;
   logic                          csr_wr_en    = 1'b0;
   logic [1:0]                    csr_index    = CSR_DELAY;
   logic [CSR_BITS-1:0]           csr_data     = '0;

   int   mismatch_count;
   int   pending_count;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   int   run_phase     = -1;
   logic hold_rsp      = 1'b0;

   stereo_feedback_delay_unit #(
      .DEPTH       (DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   stereo_feedback_delay_checker #(
      .DEPTH       (DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_left_in    (req_left_in),
      .req_right_in   (req_right_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_left_out   (rsp_left_out),
      .rsp_right_out  (rsp_right_out),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   always @(negedge clock) begin
      rsp_stall <= hold_rsp || ($urandom_range(99) < rsp_stall_pct);
   end

   // hold off the result side while items keep coming, so the input backs up
   initial begin
      wait (run_phase == 0);
      repeat (30) @(posedge clock);
      hold_rsp = 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("FAIL stereo_feedback_delay_unit");
      $finish;
   end

   function automatic logic [2*SAMPLE_BITS-1:0] corner_pair(input int i);
      case (i)
         0:  return {16'sd32767, -16'sd32768};
         1:  return {-16'sd32768, 16'sd32767};
         2:  return {16'sd0, 16'sd0};
         3:  return {-16'sd1, 16'sd1};
         4:  return {16'sd1, -16'sd1};
         5:  return {16'sd32767, 16'sd32767};
         6:  return {-16'sd32768, -16'sd32768};
         7:  return {16'sd16384, -16'sd16384};
         8:  return {16'sd0, 16'sd32767};
         9:  return {-16'sd32768, 16'sd0};
         10: return {16'sd12345, -16'sd23456};
         default: return {-16'sd1, -16'sd1};
      endcase
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] sample_value();
      case ($urandom_range(9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return SAMPLE_BITS'($urandom_range(255) - 128);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_BITS-1:0] gain_value();
      case ($urandom_range(3))
         0:       return CSR_BITS'($urandom_range(32768));
         1:       return CSR_BITS'(GAIN_ONE);
         2:       return CSR_BITS'($urandom_range(65535));
         default: return '0;
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_pair(input logic [SAMPLE_BITS-1:0] left,
                            input logic [SAMPLE_BITS-1:0] right);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_left_in  <= left;
      req_right_in <= right;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_regs(input logic [CSR_BITS-1:0] delay, input logic [CSR_BITS-1:0] fb,
                             input logic [CSR_BITS-1:0] mix, input logic [CSR_BITS-1:0] tone);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DELAY;
      csr_data  <= delay;
      @(negedge clock);
      csr_index <= CSR_FEEDBACK;
      csr_data  <= fb;
      @(negedge clock);
      csr_index <= CSR_MIX;
      csr_data  <= mix;
      @(negedge clock);
      csr_index <= CSR_TONE;
      csr_data  <= tone;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [CSR_BITS-1:0] delay;
      logic [2*SAMPLE_BITS-1:0] pair;
      int waited;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero delay, over-wide feedback and mix: all clamp; fully wet output
      write_regs(16'd0, 16'hFFFF, 16'hFFFF, CSR_BITS'(GAIN_ONE));
      for (int i = 0; i < 12; i++) begin
         pair = corner_pair(i);
         send_pair(pair[31:16], pair[15:0]);
      end
      drain();
      // delay with junk in the upper bits, maximum feedback, half mix
      write_regs(16'hF003, CSR_BITS'(FEEDBACK_MAX), 16'd16384, 16'd0);
      for (int i = 0; i < 12; i++) begin
         pair = corner_pair(11 - i);
         send_pair(pair[31:16], pair[15:0]);
      end
      drain();

      for (int p = 0; p < 8; p++) begin
         case ($urandom_range(4))
            0:       delay = CSR_BITS'($urandom_range(16, 1));
            1:       delay = CSR_BITS'($urandom_range(200, 1));
            2:       delay = CSR_BITS'($urandom_range(65535));
            3:       delay = CSR_BITS'($urandom_range(1));
            default: delay = 16'd4095;
         endcase
         if (p == 6)
            write_regs(16'd4095, 16'd0, 16'd0, 16'd0);
         else if (p == 7)
            write_regs(16'd1, CSR_BITS'(FEEDBACK_MAX), CSR_BITS'(GAIN_ONE), 16'd0);
         else
            write_regs(delay, gain_value() & 16'h7FFF | (CSR_BITS'($urandom_range(1)) << 15),
                       gain_value(), gain_value());

         case (p % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 86;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 86;
            end
            default: begin
               send_idle_pct = 15;
               rsp_stall_pct = 15;
            end
         endcase
         run_phase = p;

         for (int n = 0; n < PHASE_ITEMS; n++)
            send_pair(sample_value(), sample_value());
         drain();
      end

      req_valid <= 1'b0;
      waited = 0;
      while (pending_count != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("PASS stereo_feedback_delay_unit");
      end else begin
         $display("FAIL stereo_feedback_delay_unit");
      end
      $finish;
   end

endmodule
